// ----- hdl/b2ra_pkg.sv -----
// shared types, control-store program and ascii helpers for the radix converter
// used by the microcode sequencer and the datapath; no dependencies
`default_nettype none
package b2ra_pkg;

  localparam logic [6:0] ASCII_ZERO    = 7'd48;
  localparam logic [6:0] ASCII_A       = 7'd65;
  localparam logic [6:0] ASCII_NEWLINE = 7'd10;
  localparam logic [3:0] DIGIT_TEN     = 4'd10;
  localparam logic [4:0] RADIX_MIN     = 5'd2;
  localparam logic [4:0] RADIX_MAX     = 5'd16;
  localparam int unsigned NIB_W        = 4;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_STORE,
    OP_READ,
    OP_EMIT_DIGIT,
    OP_EMIT_NL
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_DIV_DONE,
    C_NIB_MORE,
    C_COUNT_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_LOAD      = 3'd0;
  localparam step_t STEP_DIV_START = 3'd1;
  localparam step_t STEP_DIV_STEP  = 3'd2;
  localparam step_t STEP_STORE     = 3'd3;
  localparam step_t STEP_READ      = 3'd4;
  localparam step_t STEP_EMIT      = 3'd5;
  localparam step_t STEP_NEWLINE   = 3'd6;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctl_word_t;

  typedef struct packed {
    logic no_input;
    logic div_done;
    logic nib_more;
    logic count_zero;
    logic out_busy;
  } status_t;

  // control store: jump to tgt_true when the condition holds, else tgt_false
  function automatic ctl_word_t ucode_rom(step_t pc);
    ctl_word_t w;
    unique case (pc)
      STEP_LOAD:      w = '{OP_LOAD,       C_NO_INPUT,   STEP_LOAD,     STEP_DIV_START};
      STEP_DIV_START: w = '{OP_DIV_START,  C_DIV_DONE,   STEP_READ,     STEP_DIV_STEP};
      STEP_DIV_STEP:  w = '{OP_DIV_STEP,   C_NIB_MORE,   STEP_DIV_STEP, STEP_STORE};
      STEP_STORE:     w = '{OP_STORE,      C_ALWAYS,     STEP_DIV_START, STEP_DIV_START};
      STEP_READ:      w = '{OP_READ,       C_COUNT_ZERO, STEP_NEWLINE,  STEP_EMIT};
      STEP_EMIT:      w = '{OP_EMIT_DIGIT, C_OUT_BUSY,   STEP_EMIT,     STEP_READ};
      STEP_NEWLINE:   w = '{OP_EMIT_NL,    C_OUT_BUSY,   STEP_NEWLINE,  STEP_LOAD};
      default:        w = '{OP_LOAD,       C_ALWAYS,     STEP_LOAD,     STEP_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [6:0] digit_to_ascii(logic [3:0] d);
    logic [6:0] c;
    if (d < DIGIT_TEN) begin
      c = ASCII_ZERO + 7'(d);
    end else begin
      c = ASCII_A + 7'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/b2ra_in_if.sv -----
// input channel: number and target radix with valid/ready
// no dependencies
`default_nettype none
interface b2ra_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [4:0]            radix;

  modport source (output valid, value, radix, input ready);
  modport sink   (input valid, value, radix, output ready);
endinterface
`default_nettype wire

// ----- hdl/b2ra_out_if.sv -----
// output channel: one ascii character per word with last and error flags
// no dependencies
`default_nettype none
interface b2ra_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic       last;
  logic       bad_radix;

  modport source (output valid, char_out, last, bad_radix, input ready);
  modport sink   (input valid, char_out, last, bad_radix, output ready);
endinterface
`default_nettype wire

// ----- hdl/b2ra_ucode.sv -----
// step counter and control store of the converter
// depends on b2ra_pkg
`default_nettype none
module b2ra_ucode (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire b2ra_pkg::status_t  status,
  output b2ra_pkg::op_t           op
);

  b2ra_pkg::step_t     pc;
  b2ra_pkg::step_t     pc_next;
  b2ra_pkg::ctl_word_t ctl;
  logic                take;

  assign ctl = b2ra_pkg::ucode_rom(pc);
  assign op  = ctl.op;

  always_comb begin
    unique case (ctl.cond)
      b2ra_pkg::C_ALWAYS:     take = 1'b1;
      b2ra_pkg::C_NO_INPUT:   take = status.no_input;
      b2ra_pkg::C_DIV_DONE:   take = status.div_done;
      b2ra_pkg::C_NIB_MORE:   take = status.nib_more;
      b2ra_pkg::C_COUNT_ZERO: take = status.count_zero;
      b2ra_pkg::C_OUT_BUSY:   take = status.out_busy;
      default:                take = 1'b1;
    endcase
    pc_next = take ? ctl.tgt_true : ctl.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= b2ra_pkg::STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/b2ra_datapath.sv -----
// datapath: nibble-serial divider, digit memory, output word register
// depends on b2ra_pkg, b2ra_in_if, b2ra_out_if
`default_nettype none
module b2ra_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire b2ra_pkg::op_t      op,
  output b2ra_pkg::status_t       status,
  b2ra_in_if.sink                 din,
  b2ra_out_if.source              dout
);

  localparam int QW    = VALUE_BITS - 1;
  localparam int DEPTH = VALUE_BITS - 1;
  localparam int NIB   = (QW + 3) / 4;
  localparam int QPAD  = NIB * 4;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int NW    = (NIB > 1) ? $clog2(NIB) : 1;

  logic [QPAD-1:0] quot;
  logic [3:0]      rem;
  logic [4:0]      radix_q;
  logic            bad;
  logic [CW-1:0]   count;
  logic [NW-1:0]   nib_cnt;
  logic [3:0]      rd_data;
  logic [3:0]      mem [DEPTH];

  logic            accept;
  logic            radix_ok;
  logic            out_busy;
  logic            count_zero;
  logic [7:0]      partial;
  logic [8:0]      prod;
  logic [7:0]      sub;
  logic [3:0]      qdig;
  logic [3:0]      rem_full;
  logic [CW-1:0]   count_dec;

  assign din.ready  = (op == b2ra_pkg::OP_LOAD);
  assign accept     = din.valid && din.ready;
  assign radix_ok   = (din.radix >= b2ra_pkg::RADIX_MIN) && (din.radix <= b2ra_pkg::RADIX_MAX);
  assign out_busy   = dout.valid && !dout.ready;
  assign count_zero = (count == '0);
  assign count_dec  = count - CW'(1);

  assign status.no_input   = !din.valid;
  assign status.div_done   = (quot == '0) || (count == CW'(DEPTH));
  assign status.nib_more   = (nib_cnt != NW'(NIB - 1));
  assign status.count_zero = count_zero;
  assign status.out_busy   = out_busy;

  // one radix-16 long-division step: largest k with k*radix <= partial
  always_comb begin
    partial = {rem, quot[QPAD-1 -: 4]};
    qdig    = '0;
    sub     = '0;
    for (int k = 1; k < 16; k++) begin
      prod = 9'(k) * 9'(radix_q);
      if ({1'b0, partial} >= prod) begin
        qdig = 4'(k);
        sub  = prod[7:0];
      end
    end
    rem_full = 4'(partial - sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      quot    <= '0;
      rem     <= '0;
      nib_cnt <= '0;
      bad     <= 1'b0;
      radix_q <= '0;
    end else begin
      unique case (op)
        b2ra_pkg::OP_LOAD: begin
          if (accept) begin
            bad     <= !radix_ok;
            radix_q <= din.radix;
            count   <= '0;
            quot    <= (radix_ok && !din.value[VALUE_BITS-1]) ?
                       QPAD'(din.value[QW-1:0]) : '0;
          end
        end
        b2ra_pkg::OP_DIV_START: begin
          rem     <= '0;
          nib_cnt <= '0;
        end
        b2ra_pkg::OP_DIV_STEP: begin
          quot    <= {quot[QPAD-5:0], qdig};
          rem     <= rem_full;
          nib_cnt <= nib_cnt + NW'(1);
        end
        b2ra_pkg::OP_STORE: count <= count + CW'(1);
        b2ra_pkg::OP_READ: begin
          if (!count_zero) begin
            count <= count_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == b2ra_pkg::OP_STORE) begin
      mem[count[IW-1:0]] <= rem;
    end
    if (op == b2ra_pkg::OP_READ && !count_zero) begin
      rd_data <= mem[count_dec[IW-1:0]];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (op == b2ra_pkg::OP_EMIT_DIGIT && !out_busy) begin
      dout.valid <= 1'b1;
    end else if (op == b2ra_pkg::OP_EMIT_NL && !out_busy) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == b2ra_pkg::OP_EMIT_DIGIT && !out_busy) begin
      dout.char_out  <= b2ra_pkg::digit_to_ascii(rd_data);
      dout.last      <= 1'b0;
      dout.bad_radix <= 1'b0;
    end else if (op == b2ra_pkg::OP_EMIT_NL && !out_busy) begin
      dout.char_out  <= b2ra_pkg::ASCII_NEWLINE;
      dout.last      <= 1'b1;
      dout.bad_radix <= bad;
    end
  end

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    op == b2ra_pkg::OP_DIV_STEP |=> rem < radix_q[3:0] || radix_q == b2ra_pkg::RADIX_MAX)
    else $error("remainder not below radix");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("digit count past store depth");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(op == b2ra_pkg::OP_EMIT_DIGIT || op == b2ra_pkg::OP_EMIT_NL))
    else $error("output word without emit step");

  a_bad_no_digits: assert property (@(posedge clk) disable iff (rst)
    bad && op == b2ra_pkg::OP_READ |-> count_zero)
    else $error("digits held for bad radix");

endmodule
`default_nettype wire

// ----- hdl/binary_to_radix_ascii_top.sv -----
// top level of the integer to radix-n ascii converter
// depends on b2ra_pkg, b2ra_in_if, b2ra_out_if, b2ra_ucode, b2ra_datapath
//
// din takes one word: a two's complement number and a radix. dout gives the
// digits of the number in that radix, most significant first, as ascii
// '0'-'9' / 'A'-'F', then a newline word with last set. zero or negative
// numbers give the newline only; a radix outside 2..16 gives the newline
// with bad_radix set.
// din.ready is high only while the sequencer waits for a new number, so one
// conversion runs at a time. each digit takes one division by the
// nibble-serial divider: a start step, NIB = ceil((VALUE_BITS-1)/4) nibble
// steps and a store step; each character then takes a digit memory read and
// an output register load. a number gives at most VALUE_BITS-1 digits, so
// up to 31 digits at 32 bits.
// a stalled dout holds the sequencer at its emit step; the waiting word stays
// in the output register and nothing is lost. the next number is taken after
// the newline has been loaded into the output register.
// reset (rst, synchronous) returns the sequencer to its wait step and drops
// dout.valid; the digit memory is not cleared.
`default_nettype none
module binary_to_radix_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  b2ra_in_if.sink    din,
  b2ra_out_if.source dout
);

  b2ra_pkg::op_t     op;
  b2ra_pkg::status_t status;

  b2ra_ucode u_ucode (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  b2ra_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .status (status),
    .din    (din),
    .dout   (dout)
  );

endmodule
`default_nettype wire
